// ----- src/generational_handle_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Generational handle allocator: assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define GHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define GHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator: package
// Widths, request and status codes, free stack types.
// ----------------------------------------------------------------------------
package gha_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = 6;
    localparam int GEN_W      = 32;
    localparam int CNT_W      = 7;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_STOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Freed slot index together with its already bumped generation
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } stack_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

endpackage

// ----- src/gha_channels.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator: channel interfaces
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface gha_req_if
    import gha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;

    modport source (output valid, output req_type, output slot_index,
                    output handle_generation, input ready);
    modport sink   (input valid, input req_type, input slot_index,
                    input handle_generation, output ready);
endinterface

interface gha_rsp_if
    import gha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic [CNT_W-1:0] active_count;

    modport source (output valid, output status, output out_index,
                    output out_generation, output active_count, input ready);
    modport sink   (input valid, input status, input out_index,
                    input out_generation, input active_count, output ready);
endinterface

// ----- src/generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out slot handles (index, generation) and checks them on lookup.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  req     | in  | req_type, slot_index, handle_generation
//  rsp     | out | status, out_index, out_generation, active_count
//
//  One item per cycle sustained while rsp is not stalled; rsp is valid after
//  the input register (with generation memory read), then result register.
//  The generation memory takes one write and one registered read per cycle;
//  the read is forwarded from the write of the item ahead, so back-to-back
//  items on one slot see updated state.
//  A stalled rsp holds the result; req keeps accepting until the input
//  stage is also full. Reset clears slot state at once, no clearing pass.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit
    import gha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    // input stage
    logic             s1_valid_reg;
    req_t             s1_type_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [GEN_W-1:0] s1_gen_reg;
    logic [GEN_W-1:0] s1_cur_reg;

    // result register
    logic             rsp_valid_reg;
    status_t          rsp_status_reg;
    logic [IDX_W-1:0] rsp_index_reg;
    logic [GEN_W-1:0] rsp_gen_reg;
    logic [CNT_W-1:0] rsp_count_reg;

    // slot state
    logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] busy_next;
    logic [CNT_W-1:0]      created_reg;
    logic [CNT_W-1:0]      created_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic             s1_fire;
    logic             in_ready;
    logic             accept;
    logic             slot_made;
    logic             slot_busy;
    logic [GEN_W-1:0] cur_gen;
    logic [GEN_W-1:0] bump_sum;
    logic [GEN_W-1:0] bumped;
    logic             release_ok;
    logic             handle_match;
    logic             do_release;

    status_t          status;
    logic [IDX_W-1:0] oidx;
    logic [GEN_W-1:0] ogen;
    logic             gen_we;
    logic [IDX_W-1:0] gen_wa;
    logic [GEN_W-1:0] gen_wd;

    stack_ctl_t       stk_ctl;
    stack_ctl_t       stk_ctl_fire;
    stack_entry_t     stk_push;
    stack_entry_t     stk_top;
    logic [CNT_W-1:0] stk_depth;

    assign s1_fire  = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = req.valid && in_ready;

    // slots not yet created read as generation one, whatever the memory holds
    assign slot_made    = {1'b0, s1_idx_reg} < created_reg;
    assign slot_busy    = busy_reg[s1_idx_reg];
    assign cur_gen      = slot_made ? s1_cur_reg : GEN_W'(1);
    assign bump_sum     = cur_gen + GEN_W'(1);
    assign bumped       = (bump_sum == '0) ? GEN_W'(1) : bump_sum;
    assign release_ok   = slot_made && slot_busy;
    assign handle_match = (s1_gen_reg != '0) && release_ok && (cur_gen == s1_gen_reg);

    always_comb
    begin
        status       = ST_OK;
        oidx         = s1_idx_reg;
        ogen         = cur_gen;
        busy_next    = busy_reg;
        created_next = created_reg;
        count_next   = count_reg;
        stk_ctl      = '0;
        stk_push     = '{idx: s1_idx_reg, gen: bumped};
        gen_we       = 1'b0;
        gen_wa       = s1_idx_reg;
        gen_wd       = bumped;
        do_release   = 1'b0;

        case (s1_type_reg)
            REQ_ALLOC:
            begin
                if (stk_depth != '0)
                begin
                    oidx            = stk_top.idx;
                    ogen            = stk_top.gen;
                    stk_ctl.pop     = 1'b1;
                    busy_next[oidx] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                else if (created_reg < CNT_W'(SLOT_COUNT))
                begin
                    oidx            = created_reg[IDX_W-1:0];
                    ogen            = GEN_W'(1);
                    gen_we          = 1'b1;
                    gen_wa          = created_reg[IDX_W-1:0];
                    gen_wd          = GEN_W'(1);
                    created_next    = created_reg + CNT_W'(1);
                    busy_next[oidx] = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
                else
                begin
                    status = ST_FULL;
                    oidx   = '0;
                    ogen   = '0;
                end
            end
            REQ_FREE:
            begin
                do_release = release_ok;
                if (!release_ok)
                begin
                    status = ST_BAD;
                end
            end
            REQ_LOOKUP:
            begin
                if (!handle_match)
                begin
                    status = ST_BAD;
                end
            end
            REQ_STOP:
            begin
                do_release = handle_match;
                if (!handle_match)
                begin
                    status = ST_BAD;
                end
            end
            default:
            begin
                status = ST_BAD;
            end
        endcase

        if (do_release)
        begin
            busy_next[s1_idx_reg] = 1'b0;
            gen_we                = 1'b1;
            ogen                  = bumped;
            stk_ctl.push          = stk_depth < CNT_W'(SLOT_COUNT);
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign stk_ctl_fire = s1_fire ? stk_ctl : '0;

    gha_free_stack u_free_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (stk_ctl_fire),
        .push_entry (stk_push),
        .top        (stk_top),
        .depth      (stk_depth)
    );

    // generation memory: write from the firing item, registered read for the
    // incoming item with forwarding of that same write
    always_ff @(posedge clk)
    begin
        if (s1_fire && gen_we)
        begin
            gen_mem[gen_wa] <= gen_wd;
        end
        if (accept)
        begin
            if (s1_fire && gen_we && (gen_wa == req.slot_index))
            begin
                s1_cur_reg <= gen_wd;
            end
            else
            begin
                s1_cur_reg <= gen_mem[req.slot_index];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            busy_reg      <= '0;
            created_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
                busy_reg      <= busy_next;
                created_reg   <= created_next;
                count_reg     <= count_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= req_t'(req.req_type);
            s1_idx_reg  <= req.slot_index;
            s1_gen_reg  <= req.handle_generation;
        end
        if (s1_fire)
        begin
            rsp_status_reg <= status;
            rsp_index_reg  <= oidx;
            rsp_gen_reg    <= ogen;
            rsp_count_reg  <= count_next;
        end
    end

    assign req.ready          = in_ready;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.out_index      = rsp_index_reg;
    assign rsp.out_generation = rsp_gen_reg;
    assign rsp.active_count   = rsp_count_reg;

endmodule

// ----- src/gha_free_stack.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator: free stack
// LIFO of freed slots in a memory, with the top two entries cached in
// registers so a pop never waits on a memory read.
// ----------------------------------------------------------------------------
module gha_free_stack
    import gha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stack_ctl_t       ctl,
    input  stack_entry_t     push_entry,
    output stack_entry_t     top,
    output logic [CNT_W-1:0] depth
);

    stack_entry_t     mem [SLOT_COUNT];
    stack_entry_t     top_reg;
    stack_entry_t     below_reg;
    logic [CNT_W-1:0] depth_reg;
    logic [CNT_W-1:0] depth_next;
    logic [CNT_W-1:0] refill_ptr;
    logic [IDX_W-1:0] refill_addr;

    // entry that becomes second from top after a pop
    assign refill_ptr  = depth_reg - CNT_W'(3);
    assign refill_addr = refill_ptr[IDX_W-1:0];

    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.push)
        begin
            depth_next = depth_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            depth_next = depth_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[depth_reg[IDX_W-1:0]] <= push_entry;
            top_reg                   <= push_entry;
            below_reg                 <= top_reg;
        end
        else if (ctl.pop)
        begin
            top_reg   <= below_reg;
            below_reg <= mem[refill_addr];
        end
    end

    assign top   = top_reg;
    assign depth = depth_reg;

endmodule

// ----- src/gha_checker.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator: port checker
// Watches the response channel for result consistency over time.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_unit_defines.svh"

module gha_checker
    import gha_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [1:0]       rsp_status,
    input logic [IDX_W-1:0] rsp_index,
    input logic [GEN_W-1:0] rsp_gen,
    input logic [CNT_W-1:0] rsp_count
);

    `GHA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_index) && $stable(rsp_gen) && $stable(rsp_count), "stalled item changed")
    `GHA_ASSERT(a_full_fields, rsp_valid && (rsp_status == ST_FULL) |-> (rsp_index == '0) && (rsp_gen == '0) && (rsp_count == CNT_W'(SLOT_COUNT)), "full status with bad fields")
    `GHA_ASSERT(a_ok_gen, rsp_valid && (rsp_status == ST_OK) |-> rsp_gen != '0, "ok item with zero generation")
    `GHA_ASSERT(a_count_range, rsp_valid |-> rsp_count <= CNT_W'(SLOT_COUNT), "active count out of range")
    `GHA_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !rsp_valid, "response valid in reset")

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_index  (rsp.out_index),
    .rsp_gen    (rsp.out_generation),
    .rsp_count  (rsp.active_count)
);

// ----- tb/generational_handle_allocator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives allocate, free, lookup and stop requests with random gaps and
// response stalls. A slot map model predicts every response in order.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit_test;
    import gha_pkg::*;

    typedef struct {
        status_t          code;
        logic [IDX_W-1:0] index;
        logic [GEN_W-1:0] generation;
        logic [CNT_W-1:0] active;
    } slot_result_t;

    class slot_map_tracker;
        logic [GEN_W-1:0] slot_gen [SLOT_COUNT];
        bit               slot_busy [SLOT_COUNT];
        logic [IDX_W-1:0] free_lifo [SLOT_COUNT];
        int               free_depth;
        int               created;
        int               busy_count;
        slot_result_t     pending [$];
        int               mismatches;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_gen[i]  = 1;
                slot_busy[i] = 0;
                free_lifo[i] = '0;
            end
            free_depth = 0;
            created    = 0;
            busy_count = 0;
            mismatches = 0;
        endfunction

        function bit handle_valid(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
            if (g == 0 || idx >= created || !slot_busy[idx])
                return 0;
            return slot_gen[idx] == g;
        endfunction

        function bit release_slot(logic [IDX_W-1:0] idx);
            if (idx >= created || !slot_busy[idx])
                return 0;
            slot_busy[idx] = 0;
            slot_gen[idx]  = slot_gen[idx] + 1;
            if (slot_gen[idx] == 0)
                slot_gen[idx] = 1;
            if (free_depth < SLOT_COUNT)
            begin
                free_lifo[free_depth] = idx;
                free_depth++;
            end
            if (busy_count > 0)
                busy_count--;
            return 1;
        endfunction

        function void note_request(req_t rt, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
            slot_result_t r;
            bit           granted;
            r.code  = ST_OK;
            r.index = idx;
            case (rt)
                REQ_ALLOC:
                begin
                    granted = 1;
                    if (free_depth > 0)
                    begin
                        free_depth--;
                        r.index = free_lifo[free_depth];
                    end
                    else if (created < SLOT_COUNT)
                    begin
                        r.index = created[IDX_W-1:0];
                        slot_gen[r.index] = 1;
                        created++;
                    end
                    else
                        granted = 0;
                    if (granted)
                    begin
                        slot_busy[r.index] = 1;
                        busy_count++;
                        r.generation = slot_gen[r.index];
                    end
                    else
                    begin
                        r.code       = ST_FULL;
                        r.index      = '0;
                        r.generation = '0;
                    end
                end
                REQ_FREE:
                begin
                    if (!release_slot(idx))
                        r.code = ST_BAD;
                    r.generation = slot_gen[idx];
                end
                REQ_LOOKUP:
                begin
                    if (!handle_valid(idx, g))
                        r.code = ST_BAD;
                    r.generation = slot_gen[idx];
                end
                default:
                begin
                    // stop: lookup then free, nothing changes on a bad handle
                    if (handle_valid(idx, g))
                        void'(release_slot(idx));
                    else
                        r.code = ST_BAD;
                    r.generation = slot_gen[idx];
                end
            endcase
            r.active = busy_count[CNT_W-1:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_response(logic [1:0] st, logic [IDX_W-1:0] idx,
                                     logic [GEN_W-1:0] g, logic [CNT_W-1:0] cnt);
            slot_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected item status %0d index %0d gen %0h count %0d",
                         $time, st, idx, g, cnt);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.code)
            begin
                $display("%0t: status expected %0d got %0d", $time, e.code, st);
                mismatches++;
            end
            if (idx !== e.index)
            begin
                $display("%0t: out_index expected %0d got %0d", $time, e.index, idx);
                mismatches++;
            end
            if (g !== e.generation)
            begin
                $display("%0t: out_generation expected %0h got %0h", $time, e.generation, g);
                mismatches++;
            end
            if (cnt !== e.active)
            begin
                $display("%0t: active_count expected %0d got %0d", $time, e.active, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n;
    bit   no_idle = 0;

    gha_req_if req_ch ();
    gha_rsp_if rsp_ch ();

    slot_map_tracker sb = new();

    generational_handle_allocator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    task automatic send_request(req_t rt, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
        while (!no_idle && $urandom_range(0, 99) < 13)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid             <= 1'b1;
        req_ch.req_type          <= rt;
        req_ch.slot_index        <= idx;
        req_ch.handle_generation <= g;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(rt, idx, g);
    endtask

    // hold the sender off until every response is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    function automatic void pick_request(input bit filling, output req_t rt,
                                         output logic [IDX_W-1:0] idx,
                                         output logic [GEN_W-1:0] g);
        int live [$];
        int roll;
        int pick;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (sb.slot_busy[i])
                live.insert(live.size(), i);
        roll = $urandom_range(0, 99);
        idx  = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
        g    = $urandom();
        if (roll < 10)
        begin
            // noise: any request, mostly junk or stale handles
            rt = req_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: g = '0;
                1: g = sb.slot_gen[idx];
                2: g = sb.slot_gen[idx] - 1;
                default: ;
            endcase
        end
        else if (roll < (filling ? 85 : 25) || live.size() == 0)
            rt = REQ_ALLOC;
        else
        begin
            pick = live[$urandom_range(0, live.size() - 1)];
            idx  = pick[IDX_W-1:0];
            g    = sb.slot_gen[idx];
            case ($urandom_range(0, 2))
                0: rt = REQ_FREE;
                1: rt = REQ_LOOKUP;
                default: rt = REQ_STOP;
            endcase
        end
    endfunction

    initial
    begin
        req_t             rt;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] g;
        req_ch.valid             <= 1'b0;
        req_ch.req_type          <= REQ_ALLOC;
        req_ch.slot_index        <= '0;
        req_ch.handle_generation <= '0;
        rst_n                    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_LOOKUP, 0, 1);            // never created
        send_request(REQ_FREE, 63, 0);              // never created
        send_request(REQ_STOP, 5, 0);               // zero generation
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_LOOKUP, 0, 0);             // zero generation on live slot
        send_request(REQ_LOOKUP, 0, 1);
        send_request(REQ_LOOKUP, 0, '1);            // wrong generation
        send_request(REQ_FREE, 0, '1);
        send_request(REQ_FREE, 0, 0);               // double free
        send_request(REQ_LOOKUP, 0, 1);             // stale handle
        send_request(REQ_ALLOC, 0, 0);              // reuse from free stack
        send_request(REQ_STOP, 0, 2);
        send_request(REQ_STOP, 0, 3);               // not busy any more
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_FREE, 1, 0);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_ALLOC, 0, 0);              // LIFO: slot 0 first
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_LOOKUP, 2, 1);
        send_request(REQ_STOP, 2, 1);
        wait_drained();

        for (int n = 0; n < 1750; n++)
        begin
            no_idle = (n >= 700 && n < 1000);
            if (n == 1300)
                wait_drained();
            // alternate fill and drain phases to hit full and empty
            pick_request(((n / 150) % 2) == 0, rt, idx, g);
            send_request(rt, idx, g);
        end
        no_idle = 0;
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_response(rsp_ch.status, rsp_ch.out_index,
                                  rsp_ch.out_generation, rsp_ch.active_count);
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
